### rtl/bbd_pkg.sv
// Shared types, constants and reciprocal tables for the box binning downsampler.
// No dependencies; every other file of the block imports this package.

package bbd_pkg;

    // Geometry and field widths.
    localparam int MAX_COLUMNS = 4096;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int COLS_W      = COL_W + 1;
    localparam int MAX_FACTOR  = 10;
    localparam int FACTOR_W    = 4;
    localparam int PIX_W       = 16;
    localparam int ROW_W       = 16;
    localparam int SUM_W       = 23;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COLS_W;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_FACTOR    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLUMNS = 1'b1;

    // Cycles needed after a register write before derived values are valid.
    localparam int                   SETTLE_W      = 2;
    localparam logic [SETTLE_W-1:0]  SETTLE_CYCLES = 2'd2;

    // Reciprocal scaling: x / f = (x * ceil(2^17 / f)) >> 17 for x below 2^13,
    // and s / f^2 = (s * ceil(2^30 / f^2)) >> 30 for s below 2^23, both exact.
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP_W     = 18;
    localparam int SQ_SHIFT    = 30;
    localparam int SQ_RECIP_W  = 31;

    // Configuration values after clamping, plus derived row length and a ready flag.
    typedef struct packed {
        logic [FACTOR_W-1:0] f;
        logic [COLS_W-1:0]   cols;
        logic [COLS_W-1:0]   full;
        logic                ready;
    } bbd_cfg_t;

    // ceil(2^17 / f) for f in 1..10.
    function automatic logic [RECIP_W-1:0] recip_factor(input logic [FACTOR_W-1:0] f);
        logic [RECIP_W-1:0] r;
        unique case (f)
            4'd2:    r = 18'd65536;
            4'd3:    r = 18'd43691;
            4'd4:    r = 18'd32768;
            4'd5:    r = 18'd26215;
            4'd6:    r = 18'd21846;
            4'd7:    r = 18'd18725;
            4'd8:    r = 18'd16384;
            4'd9:    r = 18'd14564;
            4'd10:   r = 18'd13108;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

    // ceil(2^30 / f^2) for f in 1..10.
    function automatic logic [SQ_RECIP_W-1:0] recip_square(input logic [FACTOR_W-1:0] f);
        logic [SQ_RECIP_W-1:0] r;
        unique case (f)
            4'd2:    r = 31'd268435456;
            4'd3:    r = 31'd119304648;
            4'd4:    r = 31'd67108864;
            4'd5:    r = 31'd42949673;
            4'd6:    r = 31'd29826162;
            4'd7:    r = 31'd21913099;
            4'd8:    r = 31'd16777216;
            4'd9:    r = 31'd13256072;
            4'd10:   r = 31'd10737419;
            default: r = 31'd1073741824;
        endcase
        return r;
    endfunction

endpackage

### rtl/box_bin_downsampler.sv
// Box binning downsampler top level: column-sum memory, block accumulator and
// reciprocal divide. Depends on bbd_pkg and bbd_cfg.
//
//  Channel  Direction  Handshake             Payload
//  input    in         in_valid / in_ready   pixel_value, frame_start
//  output   out        out_valid / out_ready binned_value, out_column, out_row
//  config   in         cfg_write             cfg_index, cfg_data
//
// One pixel is taken per clock while in_ready is high; the result of a block passes
// from the memory stage through the divide stage to the output register. The
// column-sum memory does one read and one write per clock, with forwarding when
// consecutive pixels hit the same column. A stalled output register freezes the
// whole pipeline and drops in_ready. After a register write in_ready is held low
// while the whole-block row length is recomputed. Reset needs no clearing pass.

module box_bin_downsampler
    import bbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      pixel_value,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      binned_value,
    output logic [COL_W-1:0]      out_column,
    output logic [ROW_W-1:0]      out_row
);

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [COL_W-1:0] col;
        logic             start;
        logic             row0;
        logic             cib0;
        logic             last_row;
        logic             summed;
        logic             emit;
        logic [ROW_W-1:0] orow;
    } stage_t;

    bbd_cfg_t cfg;

    // Raster counters.
    logic [COL_W-1:0]    col_reg,  col_next,  col_e;
    logic [FACTOR_W-1:0] rib_reg,  rib_next,  rib_e;
    logic [FACTOR_W-1:0] cib_reg,  cib_next,  cib_e;
    logic [ROW_W-1:0]    orow_reg, orow_next, orow_e;

    logic                adv;
    logic                accept;
    logic [FACTOR_W-1:0] f_m1;
    logic [COLS_W-1:0]   cols_m1;
    logic                last_row;
    logic                cib_end;
    logic                summed;
    logic                row_end;
    stage_t              s0;

    // Memory stage.
    logic [SUM_W-1:0] col_sum_mem [MAX_COLUMNS];
    logic [SUM_W-1:0] mem_q;
    logic             fwd_reg;
    logic [SUM_W-1:0] fwd_data_reg;
    logic             s1_valid_reg;
    stage_t           s1_reg;
    logic [SUM_W-1:0] rd_val;
    logic [SUM_W-1:0] cs;
    logic [SUM_W-1:0] bs_new;
    logic [SUM_W-1:0] block_sum_reg;
    logic             wr_en;

    // Divide stage and output register.
    logic                           s2_valid_reg;
    logic [SUM_W-1:0]               s2_sum_reg;
    logic [COL_W-1:0]               s2_col_reg;
    logic [ROW_W-1:0]               s2_row_reg;
    logic [SUM_W+SQ_RECIP_W-1:0]    quot_prod;
    logic [COL_W+RECIP_W-1:0]       col_prod;
    logic                           out_valid_reg;
    logic [PIX_W-1:0]               binned_reg;
    logic [COL_W-1:0]               out_column_reg;
    logic [ROW_W-1:0]               out_row_reg;

    bbd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline moves whenever the output register is free or being drained.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv && cfg.ready;
    assign accept   = in_valid && in_ready;

    // Front end: frame start clears the counters before the pixel is placed.
    always_comb
    begin
        col_e   = frame_start ? '0 : col_reg;
        rib_e   = frame_start ? '0 : rib_reg;
        cib_e   = frame_start ? '0 : cib_reg;
        orow_e  = frame_start ? '0 : orow_reg;
        f_m1    = cfg.f - FACTOR_W'(1);
        cols_m1 = cfg.cols - COLS_W'(1);

        last_row = (rib_e >= f_m1);
        cib_end  = (cib_e >= f_m1);
        summed   = ({1'b0, col_e} < cfg.full);
        row_end  = ({1'b0, col_e} >= cols_m1);

        s0.px       = pixel_value;
        s0.col      = col_e;
        s0.start    = frame_start;
        s0.row0     = (rib_e == '0);
        s0.cib0     = (cib_e == '0);
        s0.last_row = last_row;
        s0.summed   = summed;
        s0.emit     = summed && last_row && cib_end;
        s0.orow     = orow_e;
    end

    // Counter advance for the accepted pixel.
    always_comb
    begin
        col_next  = col_e + COL_W'(1);
        rib_next  = rib_e;
        cib_next  = cib_e;
        orow_next = orow_e;
        if (summed)
            cib_next = cib_end ? '0 : cib_e + FACTOR_W'(1);
        if (row_end)
        begin
            col_next = '0;
            cib_next = '0;
            if (last_row)
            begin
                rib_next = '0;
                if (orow_e != '1)
                    orow_next = orow_e + ROW_W'(1);
            end
            else
            begin
                rib_next = rib_e + FACTOR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            rib_reg  <= '0;
            cib_reg  <= '0;
            orow_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            rib_reg  <= rib_next;
            cib_reg  <= cib_next;
            orow_reg <= orow_next;
        end
    end

    // Column-sum read-modify-write; the first row of a band starts from zero.
    assign rd_val = fwd_reg ? fwd_data_reg : mem_q;
    assign cs     = (s1_reg.row0 ? '0 : rd_val) + SUM_W'(s1_reg.px);
    assign bs_new = (s1_reg.cib0 ? '0 : block_sum_reg) + cs;
    assign wr_en  = s1_valid_reg && adv && s1_reg.summed;

    // Column-sum memory: one read on accept, one write from the memory stage.
    always_ff @(posedge clk)
    begin
        if (accept)
            mem_q <= col_sum_mem[col_e];
        if (wr_en)
            col_sum_mem[s1_reg.col] <= cs;
    end

    // Forward the sum being written when the new request reads the same column.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else if (accept)
            fwd_reg <= wr_en && (s1_reg.col == col_e);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            fwd_data_reg <= cs;
    end

    // Stage valids and output valid. A frame start that adds nothing to the
    // block sum still clears it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            block_sum_reg <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg && s1_reg.emit;
            out_valid_reg <= s2_valid_reg;
            if (s1_valid_reg && s1_reg.summed && s1_reg.last_row)
                block_sum_reg <= bs_new;
            else if (s1_valid_reg && s1_reg.start)
                block_sum_reg <= '0;
        end
    end

    // Reciprocal multiplies for the block average and the output column.
    assign quot_prod = (SUM_W + SQ_RECIP_W)'(s2_sum_reg)
                     * (SUM_W + SQ_RECIP_W)'(recip_square(cfg.f));
    assign col_prod  = (COL_W + RECIP_W)'(s2_col_reg)
                     * (COL_W + RECIP_W)'(recip_factor(cfg.f));

    // Payload registers along the pipeline.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg         <= s0;
            s2_sum_reg     <= bs_new;
            s2_col_reg     <= s1_reg.col;
            s2_row_reg     <= s1_reg.orow;
            binned_reg     <= quot_prod[SQ_SHIFT +: PIX_W];
            out_column_reg <= col_prod[RECIP_SHIFT +: COL_W];
            out_row_reg    <= s2_row_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign binned_value = binned_reg;
    assign out_column   = out_column_reg;
    assign out_row      = out_row_reg;

    // A register write keeps input closed on the following cycle.
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !in_ready)
        else $error("input accepted right after a register write");

    // A result only reaches the output register from the divide stage.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("result appeared without a divide-stage entry");

    // A block closes only on a summed pixel of the band's last row.
    a_emit_cond: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.emit) |-> (s1_reg.summed && s1_reg.last_row))
        else $error("block emitted outside a summed last-row pixel");

    // A held result blocks new input.
    a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while output stalled");

endmodule

### rtl/bbd_cfg.sv
// Configuration registers of the box binning downsampler, with clamping and the
// derived length of the summed part of a row. Depends on bbd_pkg.

module bbd_cfg
    import bbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output bbd_cfg_t              cfg
);

    logic [FACTOR_W-1:0] bin_factor_reg;
    logic [COLS_W-1:0]   image_columns_reg;
    logic [COLS_W-1:0]   quot_reg;
    logic [COLS_W-1:0]   quot_next;
    logic [COLS_W-1:0]   full_reg;
    logic [COLS_W-1:0]   full_next;
    logic [SETTLE_W-1:0] settle_reg;
    logic [SETTLE_W-1:0] settle_next;

    logic [FACTOR_W-1:0]        f_clamped;
    logic [COLS_W-1:0]          cols_clamped;
    logic [COLS_W+RECIP_W-1:0]  quot_prod;
    logic [COLS_W+FACTOR_W-1:0] full_prod;

    // Out-of-range register values act as the nearest legal value.
    always_comb
    begin
        if (bin_factor_reg == '0)
            f_clamped = FACTOR_W'(1);
        else if (bin_factor_reg > FACTOR_W'(MAX_FACTOR))
            f_clamped = FACTOR_W'(MAX_FACTOR);
        else
            f_clamped = bin_factor_reg;

        if (image_columns_reg == '0)
            cols_clamped = COLS_W'(1);
        else if (image_columns_reg > COLS_W'(MAX_COLUMNS))
            cols_clamped = COLS_W'(MAX_COLUMNS);
        else
            cols_clamped = image_columns_reg;
    end

    // Whole-block row length (cols / f) * f in two registered multiply steps.
    assign quot_prod = (COLS_W + RECIP_W)'(cols_clamped)
                     * (COLS_W + RECIP_W)'(recip_factor(f_clamped));
    assign quot_next = COLS_W'(quot_prod >> RECIP_SHIFT);
    assign full_prod = (COLS_W + FACTOR_W)'(quot_reg) * (COLS_W + FACTOR_W)'(f_clamped);
    assign full_next = COLS_W'(full_prod);

    // Hold off input until the derived length has caught up with a write.
    always_comb
    begin
        if (cfg_write)
            settle_next = SETTLE_CYCLES;
        else if (settle_reg != '0)
            settle_next = settle_reg - SETTLE_W'(1);
        else
            settle_next = settle_reg;
    end

    // Register file and derived values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_factor_reg    <= FACTOR_W'(1);
            image_columns_reg <= COLS_W'(MAX_COLUMNS);
            quot_reg          <= COLS_W'(MAX_COLUMNS);
            full_reg          <= COLS_W'(MAX_COLUMNS);
            settle_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_BIN_FACTOR:    bin_factor_reg    <= cfg_data[FACTOR_W-1:0];
                    REG_IMAGE_COLUMNS: image_columns_reg <= cfg_data[COLS_W-1:0];
                    default:           ;
                endcase
            end
            quot_reg   <= quot_next;
            full_reg   <= full_next;
            settle_reg <= settle_next;
        end
    end

    assign cfg.f     = f_clamped;
    assign cfg.cols  = cols_clamped;
    assign cfg.full  = full_reg;
    assign cfg.ready = (settle_reg == '0);

endmodule
